// ----- design/beam_combine_weighted_sum_top_assert.svh -----
// ----------------------------------------------------------------------------
// Beam combiner assertion macros
// Implication checks on a clock with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BEAM_COMBINE_WEIGHTED_SUM_TOP_ASSERT_SVH
`define BEAM_COMBINE_WEIGHTED_SUM_TOP_ASSERT_SVH

// same-cycle implication
`define BCWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("beam combiner check failed");

// next-cycle implication
`define BCWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("beam combiner check failed");

`endif

// ----- design/bcws_pkg.sv -----
// ----------------------------------------------------------------------------
// Beam combiner package
// Widths, register indexes and payload types of the weighted-sum combiner.
// ----------------------------------------------------------------------------
package bcws_pkg;

  localparam int CHANNELS = 4;
  localparam int MAX_CH   = 4;
  localparam int CH_IDX_W = $clog2(MAX_CH);

  localparam int SAMP_W = 4;
  localparam int WGT_W  = 16;
  localparam int CFG_W  = 2 * WGT_W;
  localparam int PROD_W = SAMP_W + WGT_W;
  localparam int LANE_W = PROD_W + 1;
  localparam int SUM_W  = LANE_W + $clog2(CHANNELS);
  localparam int RND_W  = SUM_W + 1;
  localparam int ADJ_W  = RND_W + 1;

  localparam int FRAC_W  = 8;
  localparam int Q_SCALE = 1 << FRAC_W;
  localparam int HALF    = Q_SCALE / 2;
  localparam int OUT_W   = 4;
  localparam int OUT_MIN = -8;
  localparam int OUT_MAX = 7;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd4;

  typedef struct packed {
    logic signed [SAMP_W-1:0] ch0_i;
    logic signed [SAMP_W-1:0] ch0_q;
    logic signed [SAMP_W-1:0] ch1_i;
    logic signed [SAMP_W-1:0] ch1_q;
    logic signed [SAMP_W-1:0] ch2_i;
    logic signed [SAMP_W-1:0] ch2_q;
    logic signed [SAMP_W-1:0] ch3_i;
    logic signed [SAMP_W-1:0] ch3_q;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_i;
    logic signed [OUT_W-1:0] out_q;
  } out_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] i;
    logic signed [SAMP_W-1:0] q;
  } sample_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] re;
    logic signed [LANE_W-1:0] im;
  } lane_t;

endpackage

// ----- design/bcws_in_if.sv -----
// ----------------------------------------------------------------------------
// Beam combiner input channel
// Valid/ready request carrying one sample from every antenna channel.
// ----------------------------------------------------------------------------
interface bcws_in_if;
  logic           valid;
  logic           ready;
  bcws_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bcws_out_if.sv -----
// ----------------------------------------------------------------------------
// Beam combiner output channel
// Valid/ready request carrying one combined I/Q sample.
// ----------------------------------------------------------------------------
interface bcws_out_if;
  logic           valid;
  logic           ready;
  bcws_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/bcws_lane.sv -----
// ----------------------------------------------------------------------------
// Beam combiner lane
// Complex multiply of one channel sample by its weight, registered.
// ----------------------------------------------------------------------------
module bcws_lane (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  bcws_pkg::sample_t             samp_i,
  input  logic [bcws_pkg::CFG_W-1:0]    weight_i,
  output bcws_pkg::lane_t               res_o
);

  logic signed [bcws_pkg::WGT_W-1:0]  wr;
  logic signed [bcws_pkg::WGT_W-1:0]  wi;
  logic signed [bcws_pkg::PROD_W-1:0] p_iwr;
  logic signed [bcws_pkg::PROD_W-1:0] p_qwi;
  logic signed [bcws_pkg::PROD_W-1:0] p_iwi;
  logic signed [bcws_pkg::PROD_W-1:0] p_qwr;
  bcws_pkg::lane_t                    res_d;
  bcws_pkg::lane_t                    res_q;

  assign wr = $signed(weight_i[bcws_pkg::WGT_W-1:0]);
  assign wi = $signed(weight_i[bcws_pkg::CFG_W-1:bcws_pkg::WGT_W]);

  assign p_iwr = samp_i.i * wr;
  assign p_qwi = samp_i.q * wi;
  assign p_iwi = samp_i.i * wi;
  assign p_qwr = samp_i.q * wr;

  always_comb begin
    res_d.re = bcws_pkg::LANE_W'(p_iwr) - bcws_pkg::LANE_W'(p_qwi);
    res_d.im = bcws_pkg::LANE_W'(p_iwi) + bcws_pkg::LANE_W'(p_qwr);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ----- design/bcws_merge.sv -----
// ----------------------------------------------------------------------------
// Beam combiner merge
// Sum of the lane products, then round, scale and saturate into the output.
// ----------------------------------------------------------------------------
module bcws_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lane_valid_i,
  output logic              lane_ready_o,
  input  bcws_pkg::lane_t   lane_i [bcws_pkg::CHANNELS],
  bcws_out_if.source        out_o
);

  logic                               sum_valid_q;
  logic                               out_valid_q;
  logic                               sum_en;
  logic                               out_en;
  logic signed [bcws_pkg::SUM_W-1:0]  sum_re_d;
  logic signed [bcws_pkg::SUM_W-1:0]  sum_im_d;
  logic signed [bcws_pkg::SUM_W-1:0]  sum_re_q;
  logic signed [bcws_pkg::SUM_W-1:0]  sum_im_q;
  bcws_pkg::out_t                     out_d;
  bcws_pkg::out_t                     out_q;

  function automatic logic signed [bcws_pkg::OUT_W-1:0] round_clip(
    input logic signed [bcws_pkg::SUM_W-1:0] s
  );
    logic                              neg;
    logic signed [bcws_pkg::RND_W-1:0] rnd;
    logic signed [bcws_pkg::ADJ_W-1:0] adj;
    logic signed [bcws_pkg::ADJ_W-1:0] quo;
    logic signed [bcws_pkg::OUT_W-1:0] res;
    neg = s[bcws_pkg::SUM_W-1];
    if (neg) begin
      rnd = bcws_pkg::RND_W'(s) - bcws_pkg::RND_W'(bcws_pkg::HALF);
      adj = bcws_pkg::ADJ_W'(rnd) + bcws_pkg::ADJ_W'(bcws_pkg::Q_SCALE - 1);
    end else begin
      rnd = bcws_pkg::RND_W'(s) + bcws_pkg::RND_W'(bcws_pkg::HALF);
      adj = bcws_pkg::ADJ_W'(rnd);
    end
    quo = adj >>> bcws_pkg::FRAC_W;
    if (quo < bcws_pkg::ADJ_W'(bcws_pkg::OUT_MIN)) begin
      res = bcws_pkg::OUT_W'(bcws_pkg::OUT_MIN);
    end else if (quo > bcws_pkg::ADJ_W'(bcws_pkg::OUT_MAX)) begin
      res = bcws_pkg::OUT_W'(bcws_pkg::OUT_MAX);
    end else begin
      res = quo[bcws_pkg::OUT_W-1:0];
    end
    return res;
  endfunction

  assign out_en       = !out_valid_q || out_o.ready;
  assign sum_en       = !sum_valid_q || out_en;
  assign lane_ready_o = sum_en;

  always_comb begin
    sum_re_d = '0;
    sum_im_d = '0;
    for (int c = 0; c < bcws_pkg::CHANNELS; c++) begin
      sum_re_d = sum_re_d + bcws_pkg::SUM_W'(lane_i[c].re);
      sum_im_d = sum_im_d + bcws_pkg::SUM_W'(lane_i[c].im);
    end
  end

  always_comb begin
    out_d.out_i = round_clip(sum_re_q);
    out_d.out_q = round_clip(sum_im_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_valid_q <= lane_valid_i;
      end
      if (out_en) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en && lane_valid_i) begin
      sum_re_q <= sum_re_d;
      sum_im_q <= sum_im_d;
    end
    if (out_en && sum_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule

// ----- design/beam_combine_weighted_sum_top.sv -----
// ----------------------------------------------------------------------------
// Beam combiner top level
// Complex weighted sum of four antenna channels into one I/Q sample.
//
// in_i carries one 4-bit I/Q sample per channel; out_o carries the combined
// sample, rounded half away from zero, scaled by 1/256 and saturated to 4 bits.
// Weights and the enable are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// (indexes 0..3 weights, 4 enable, others dropped); the user must write them
// only while the block is idle, which the block does not enforce. An accepted
// request with the enable clear yields no result. Stages: lane multiply,
// lane sum, round/saturate. Throughput is one request per cycle while out_o
// does not stall, set by the per-channel multiplier lanes and a three-stage
// valid/ready pipeline. A stall on out_o holds the output register; earlier
// stages keep filling until full, then in_i.ready drops. Reset clears
// weights, enable and all valid flags; no result is pending afterward.
// ----------------------------------------------------------------------------
module beam_combine_weighted_sum_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcws_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bcws_pkg::CFG_W-1:0]        cfg_wdata_i,
  bcws_in_if.sink                           in_i,
  bcws_out_if.source                        out_o
);

  `include "beam_combine_weighted_sum_top_assert.svh"

  logic [bcws_pkg::CFG_W-1:0]     weight_q [bcws_pkg::MAX_CH];
  logic                           enable_q;
  logic [bcws_pkg::CFG_IDX_W-1:0] widx;
  logic                           lane_valid_q;
  logic                           lane_ready;
  logic                           accept;
  bcws_pkg::sample_t              samp [bcws_pkg::MAX_CH];
  bcws_pkg::lane_t                lane_res [bcws_pkg::CHANNELS];

  assign widx = cfg_idx_i - bcws_pkg::CFG_WEIGHT_BASE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < bcws_pkg::MAX_CH; k++) begin
        weight_q[k] <= '0;
      end
      enable_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bcws_pkg::CFG_ENABLE) begin
        enable_q <= cfg_wdata_i[0];
      end else if (widx < bcws_pkg::CFG_IDX_W'(bcws_pkg::MAX_CH)) begin
        weight_q[widx[bcws_pkg::CH_IDX_W-1:0]] <= cfg_wdata_i;
      end
    end
  end

  assign samp[0].i = in_i.data.ch0_i;
  assign samp[0].q = in_i.data.ch0_q;
  assign samp[1].i = in_i.data.ch1_i;
  assign samp[1].q = in_i.data.ch1_q;
  assign samp[2].i = in_i.data.ch2_i;
  assign samp[2].q = in_i.data.ch2_q;
  assign samp[3].i = in_i.data.ch3_i;
  assign samp[3].q = in_i.data.ch3_q;

  assign in_i.ready = !lane_valid_q || lane_ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      lane_valid_q <= in_i.valid && enable_q;
    end
  end

  for (genvar c = 0; c < bcws_pkg::CHANNELS; c++) begin : g_lane
    bcws_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (accept),
      .samp_i   (samp[c]),
      .weight_i (weight_q[c]),
      .res_o    (lane_res[c])
    );
  end

  bcws_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lane_valid_i (lane_valid_q),
    .lane_ready_o (lane_ready),
    .lane_i       (lane_res),
    .out_o        (out_o)
  );

  `BCWS_ASSERT_NEXT(a_drop_disabled, clk_i, rst_ni, accept && !enable_q, !lane_valid_q)
  `BCWS_ASSERT_NEXT(a_take_enabled, clk_i, rst_ni, accept && enable_q, lane_valid_q)
  `BCWS_ASSERT_NEXT(a_lane_hold, clk_i, rst_ni, lane_valid_q && !lane_ready, lane_valid_q)
  `BCWS_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !lane_valid_q, in_i.ready)

endmodule
